// ----- rtl/sbs_pkg.sv -----
`default_nettype none

package sbs_pkg;

	// stream table size, ids at or above it are ignored
	localparam int STREAM_SLOTS = 128;

	// field widths
	localparam int ID_W   = 7;
	localparam int CAT_W  = 2;
	localparam int RATE_W = 32;
	localparam int CAP_W  = 31;
	localparam int SUM_W  = 33;
	localparam int CMP_W  = 35;

	// packed stream widths
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 48;

	// category codes
	localparam logic [CAT_W-1:0] CAT_AUDIO = 2'd1;
	localparam logic [CAT_W-1:0] CAT_VIDEO = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_BITRATE_CAP = 2'd0;
	localparam logic [1:0] REG_SELECT_ALL  = 2'd1;
	localparam logic [1:0] REG_WANT_AUDIO  = 2'd2;
	localparam logic [1:0] REG_WANT_VIDEO  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/stream_bitrate_selector_unit.sv -----
// Stream bitrate selector.
// Descriptor words enter on the s_ group: s_tdata carries stream id and
// declared bitrate, s_tuser the category, s_tlast marks the last descriptor of
// a header. Each descriptor gives exactly one result word on the m_ group:
// selected flag, current audio and video picks and the running bitrate total;
// m_tlast copies the descriptor's last mark, after which the picks and the
// total are cleared for the next header.
// A descriptor is held in an input register, decided by one compare-and-update
// step against the pick of its kind, and lands in the output register. One
// descriptor per cycle is sustained while the receiver keeps m_tready high,
// set by the single state update step per word.
// When the receiver stalls, the output register holds its word and the input
// register still takes one more word; s_tready drops only when both are full.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the cap, select-all and
// audio/video enables; the user must write it only while idle (not enforced).
// Reset clears the picks, the total, both valid flags and sets the enables.
`default_nettype none

module stream_bitrate_selector_unit
	import sbs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [CAP_W-1:0]    cfg_data,
	// descriptor input
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,   // stream_id[6:0], bitrate[38:7], zero pad
	input  wire logic [CAT_W-1:0]    s_tuser,   // category[1:0]
	input  wire logic                s_tlast,   // last_stream
	// result output
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // stream_selected[0], audio_choice[7:1],
	                                            // video_choice[14:8], total_bitrate[46:15], pad
	output logic                     m_tlast    // final_res
);

	// configuration registers
	logic [CAP_W-1:0] cap_q;
	logic             select_all_q;
	logic             want_audio_q;
	logic             want_video_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= '0;
			select_all_q <= 1'b0;
			want_audio_q <= 1'b1;
			want_video_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BITRATE_CAP: cap_q        <= cfg_data;
				REG_SELECT_ALL:  select_all_q <= cfg_data[0];
				REG_WANT_AUDIO:  want_audio_q <= cfg_data[0];
				REG_WANT_VIDEO:  want_video_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake control
	logic valid_s1;
	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	logic [ID_W-1:0]          id_s1;
	logic [CAT_W-1:0]         cat_s1;
	logic signed [RATE_W-1:0] rate_s1;
	logic                     last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			id_s1   <= s_tdata[ID_W-1:0];
			rate_s1 <= s_tdata[ID_W +: RATE_W];
			cat_s1  <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	// selection state
	logic [ID_W-1:0]          audio_pick_q;
	logic signed [RATE_W-1:0] audio_rate_q;
	logic [ID_W-1:0]          video_pick_q;
	logic signed [RATE_W-1:0] video_rate_q;
	logic [SUM_W-1:0]         rate_sum_q;

	// pick of the incoming word's kind
	logic                     is_audio;
	logic                     is_video;
	logic                     id_ok;
	logic [ID_W-1:0]          cur_pick;
	logic signed [RATE_W-1:0] cur_rate;

	assign is_audio = (cat_s1 == CAT_AUDIO);
	assign is_video = (cat_s1 == CAT_VIDEO);
	assign id_ok    = (id_s1 != '0) && ({2'b00, id_s1} < 9'(STREAM_SLOTS));
	assign cur_pick = is_audio ? audio_pick_q : video_pick_q;
	assign cur_rate = is_audio ? audio_rate_q : video_rate_q;

	// compare and swap decision, all in wide signed arithmetic
	logic signed [CMP_W-1:0] r_w;
	logic signed [CMP_W-1:0] pr_w;
	logic signed [CMP_W-1:0] sum_w;
	logic signed [CMP_W-1:0] cap_w;
	logic signed [CMP_W-1:0] swap_sum;
	logic signed [CMP_W-1:0] next_sum;
	logic                    has_pick;
	logic                    faster;
	logic                    slower;
	logic                    take;
	logic                    consider;
	logic                    update;
	logic                    sel;

	always_comb begin
		r_w      = CMP_W'(rate_s1);
		pr_w     = CMP_W'(cur_rate);
		sum_w    = $signed({2'b00, rate_sum_q});
		cap_w    = $signed({4'b0000, cap_q});
		has_pick = (cur_pick != '0);
		swap_sum = sum_w + r_w - pr_w;
		faster   = (r_w > pr_w) && ((swap_sum < cap_w) || (cap_q == '0));
		slower   = (r_w < pr_w) && (cap_q != '0) && (sum_w > cap_w);
		take     = !has_pick || faster || slower;
		next_sum = sum_w;
		if (has_pick && (pr_w > 0)) begin
			next_sum = next_sum - pr_w;
		end
		if (r_w > 0) begin
			next_sum = next_sum + r_w;
		end
		consider = id_ok && !select_all_q &&
			((is_audio && want_audio_q) || (!is_audio && is_video && want_video_q));
		update   = consider && take;
		if (!id_ok) begin
			sel = 1'b0;
		end else if (select_all_q) begin
			sel = is_audio || is_video;
		end else begin
			sel = update;
		end
	end

	// state after this word, before the end-of-header clear
	logic [ID_W-1:0]  audio_next;
	logic [ID_W-1:0]  video_next;
	logic [SUM_W-1:0] sum_next;

	assign audio_next = (update && is_audio) ? id_s1 : audio_pick_q;
	assign video_next = (update && !is_audio) ? id_s1 : video_pick_q;
	assign sum_next   = update ? next_sum[SUM_W-1:0] : rate_sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_pick_q <= '0;
			audio_rate_q <= '0;
			video_pick_q <= '0;
			video_rate_q <= '0;
			rate_sum_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				audio_pick_q <= '0;
				audio_rate_q <= '0;
				video_pick_q <= '0;
				video_rate_q <= '0;
				rate_sum_q   <= '0;
			end else begin
				audio_pick_q <= audio_next;
				video_pick_q <= video_next;
				rate_sum_q   <= sum_next;
				if (update && is_audio) begin
					audio_rate_q <= rate_s1;
				end
				if (update && !is_audio) begin
					video_rate_q <= rate_s1;
				end
			end
		end
	end

	// output register
	logic             out_sel_q;
	logic [ID_W-1:0]  out_audio_q;
	logic [ID_W-1:0]  out_video_q;
	logic [RATE_W-1:0] out_sum_q;
	logic             out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_sel_q   <= sel;
			out_audio_q <= audio_next;
			out_video_q <= video_next;
			out_sum_q   <= sum_next[RATE_W-1:0];
			out_last_q  <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_sum_q, out_video_q, out_audio_q, out_sel_q};
	assign m_tlast  = out_last_q;

	// checks
	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled while output register free");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (audio_pick_q == '0 && video_pick_q == '0 &&
			rate_sum_q == '0))
		else $error("state not cleared after end of header");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rate_sum_q <= 33'h0_FFFF_FFFE)
		else $error("bitrate total out of range");

	a_no_pick_no_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(audio_pick_q == '0) |-> (audio_rate_q == '0))
		else $error("audio rate held without audio pick");

endmodule

`default_nettype wire
